// ----- rtl/rtn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtn_pkg
// Types, constants and helpers shared by the RTC time normalizer.
// ----------------------------------------------------------------------------
package rtn_pkg;

   typedef struct packed {
      logic bcd_mode;
      logic twelve_hour_mode;
      logic clock_ready;
   } rtn_cfg_type;

   typedef logic [1:0] rtn_reg_type;

   localparam rtn_reg_type REG_BCD_MODE    = 2'd0;
   localparam rtn_reg_type REG_TWELVE_HOUR = 2'd1;
   localparam rtn_reg_type REG_CLOCK_READY = 2'd2;

   localparam int unsigned PM_BIT      = 7;
   localparam logic [7:0]  WINDOW_LOW  = 8'd70;
   localparam logic [7:0]  WINDOW_HIGH = 8'd99;
   localparam logic [7:0]  NOON        = 8'd12;
   localparam logic [11:0] CENTURY_19  = 12'd1900;
   localparam logic [11:0] CENTURY_20  = 12'd2000;
   localparam logic [11:0] CENTURY_21  = 12'd2100;
   localparam logic [11:0] CENTURY_22  = 12'd2200;

   localparam logic [7:0]  EPOCH_DAY     = 8'd1;
   localparam logic [7:0]  EPOCH_MONTH   = 8'd1;
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;

   // floor(x/10) = (x*RECIP10)>>16 for x < 16384
   localparam logic [12:0] RECIP10 = 13'd6554;
   // floor(x/7) = (x*RECIP7)>>16 for x < 1872
   localparam logic [13:0] RECIP7  = 14'd9363;

   function automatic logic [7:0] decode_byte(input logic [7:0] v, input logic bcd);
      logic [7:0] tens;
      tens = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0};
      decode_byte = bcd ? (tens + {4'b0000, v[3:0]}) : v;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rtc_time_normalizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_time_normalizer
// Decodes a raw RTC register snapshot into binary time, 24-hour hours,
// a windowed four-digit year and the weekday.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one snapshot of the six raw clock bytes; a transaction
//   completes when req_valid is high and req_stall is low.
//   rsp_* carries the decoded time; a transaction completes when rsp_valid
//   is high and rsp_stall is low.
//   csr_* is an APB-style port: 0x0 bcd_mode, 0x4 twelve_hour_mode,
//   0x8 clock_ready (bit 0 each). pready is tied high. Change the
//   configuration only while the pipeline is empty.
//   Requests pass through a four-stage pipeline to the response: decode,
//   Zeller setup (month term multiply), Zeller sum, mod-7 reduction;
//   throughput is one transaction per cycle while rsp_stall is low.
//   When rsp_stall is held, each stage holds its transaction and empty
//   stages still fill; req_stall rises once every stage is occupied.
//   Reset empties the pipeline and clears the configuration registers, so the block
//   returns the epoch 1970-01-01 00:00:00 Thursday until clock_ready is set.
// ----------------------------------------------------------------------------
module rtc_time_normalizer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_raw_seconds,
   input  wire logic [7:0]   req_raw_minutes,
   input  wire logic [7:0]   req_raw_hours,
   input  wire logic [7:0]   req_raw_day,
   input  wire logic [7:0]   req_raw_month,
   input  wire logic [7:0]   req_raw_year,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_seconds,
   output logic [7:0]        rsp_minutes,
   output logic [7:0]        rsp_hours,
   output logic [2:0]        rsp_weekday,
   output logic [7:0]        rsp_month_day,
   output logic [7:0]        rsp_month,
   output logic [11:0]       rsp_full_year,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import rtn_pkg::*;

   rtn_cfg_type cfg;

   rtn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   // pipeline control
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv    = ~s4_vld_ff | ~rsp_stall;
   assign s3_adv    = ~s3_vld_ff | s4_adv;
   assign s2_adv    = ~s2_vld_ff | s3_adv;
   assign s1_adv    = ~s1_vld_ff | s2_adv;
   assign req_stall = ~s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_adv) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_adv) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_adv) begin
            s4_vld_ff <= s3_vld_ff;
         end
      end
   end

   // stage 1: byte decode, hour format, year window
   logic [7:0]  s1_sec_ff, s1_min_ff, s1_hr_ff, s1_day_ff, s1_mon_ff;
   logic [11:0] s1_year_ff;
   logic [7:0]  s1_sec_in, s1_min_in, s1_hr_in, s1_day_in, s1_mon_in;
   logic [11:0] s1_year_in;
   logic [7:0]  hr_raw, hr_dec, yr_dec;
   logic        hr_pm;

   always_comb begin
      hr_pm  = cfg.twelve_hour_mode & req_raw_hours[PM_BIT];
      hr_raw = cfg.twelve_hour_mode ? {1'b0, req_raw_hours[6:0]} : req_raw_hours;
      hr_dec = decode_byte(hr_raw, cfg.bcd_mode);
      if (cfg.twelve_hour_mode && hr_dec == NOON) begin
         hr_dec = 8'd0;
      end
      if (hr_pm) begin
         hr_dec = hr_dec + NOON;
      end
      yr_dec = decode_byte(req_raw_year, cfg.bcd_mode);
      if (cfg.clock_ready) begin
         s1_sec_in  = decode_byte(req_raw_seconds, cfg.bcd_mode);
         s1_min_in  = decode_byte(req_raw_minutes, cfg.bcd_mode);
         s1_hr_in   = hr_dec;
         s1_day_in  = decode_byte(req_raw_day, cfg.bcd_mode);
         s1_mon_in  = decode_byte(req_raw_month, cfg.bcd_mode);
         s1_year_in = ((yr_dec >= WINDOW_LOW) && (yr_dec <= WINDOW_HIGH))
                      ? CENTURY_19 + {4'd0, yr_dec} : CENTURY_20 + {4'd0, yr_dec};
      end else begin
         s1_sec_in  = 8'd0;
         s1_min_in  = 8'd0;
         s1_hr_in   = 8'd0;
         s1_day_in  = EPOCH_DAY;
         s1_mon_in  = EPOCH_MONTH;
         s1_year_in = EPOCH_YEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_sec_ff  <= s1_sec_in;
         s1_min_ff  <= s1_min_in;
         s1_hr_ff   <= s1_hr_in;
         s1_day_ff  <= s1_day_in;
         s1_mon_ff  <= s1_mon_in;
         s1_year_ff <= s1_year_in;
      end
   end

   // stage 2: Zeller setup - month term, century split
   logic [7:0]  s2_sec_ff, s2_min_ff, s2_hr_ff, s2_day_ff, s2_mon_ff;
   logic [11:0] s2_year_ff;
   logic [9:0]  s2_mterm_ff, s2_mterm_in;
   logic [6:0]  s2_k_ff, s2_k_in;
   logic [4:0]  s2_j_ff, s2_j_in;
   logic [7:0]  m_adj;
   logic [11:0] y_adj, cent;
   logic [12:0] m26;
   logic [25:0] m_prod;

   always_comb begin
      if (s1_mon_ff < 8'd3) begin
         m_adj = s1_mon_ff + 8'd12;
         y_adj = s1_year_ff - 12'd1;
      end else begin
         m_adj = s1_mon_ff;
         y_adj = s1_year_ff;
      end
      m26         = ({5'd0, m_adj} + 13'd1) * 13'd26;
      m_prod      = 26'(m26) * 26'(RECIP10);
      s2_mterm_in = m_prod[25:16];
      if (y_adj >= CENTURY_22) begin
         s2_j_in = 5'd22;
         cent    = CENTURY_22;
      end else if (y_adj >= CENTURY_21) begin
         s2_j_in = 5'd21;
         cent    = CENTURY_21;
      end else if (y_adj >= CENTURY_20) begin
         s2_j_in = 5'd20;
         cent    = CENTURY_20;
      end else begin
         s2_j_in = 5'd19;
         cent    = CENTURY_19;
      end
      s2_k_in = 7'(y_adj - cent);
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_sec_ff   <= s1_sec_ff;
         s2_min_ff   <= s1_min_ff;
         s2_hr_ff    <= s1_hr_ff;
         s2_day_ff   <= s1_day_ff;
         s2_mon_ff   <= s1_mon_ff;
         s2_year_ff  <= s1_year_ff;
         s2_mterm_ff <= s2_mterm_in;
         s2_k_ff     <= s2_k_in;
         s2_j_ff     <= s2_j_in;
      end
   end

   // stage 3: Zeller sum
   logic [7:0]  s3_sec_ff, s3_min_ff, s3_hr_ff, s3_day_ff, s3_mon_ff;
   logic [11:0] s3_year_ff;
   logic [10:0] s3_sum_ff, s3_sum_in;

   always_comb begin
      s3_sum_in = {3'd0, s2_day_ff} + {1'b0, s2_mterm_ff} + {4'd0, s2_k_ff}
                + {6'd0, s2_k_ff[6:2]} + {8'd0, s2_j_ff[4:2]}
                + {4'd0, s2_j_ff, 2'b00} + {6'd0, s2_j_ff};
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_sec_ff  <= s2_sec_ff;
         s3_min_ff  <= s2_min_ff;
         s3_hr_ff   <= s2_hr_ff;
         s3_day_ff  <= s2_day_ff;
         s3_mon_ff  <= s2_mon_ff;
         s3_year_ff <= s2_year_ff;
         s3_sum_ff  <= s3_sum_in;
      end
   end

   // stage 4: mod 7, output register
   logic [7:0]  s4_sec_ff, s4_min_ff, s4_hr_ff, s4_day_ff, s4_mon_ff;
   logic [11:0] s4_year_ff;
   logic [2:0]  s4_wday_ff, s4_wday_in;
   logic [24:0] q_prod;
   logic [8:0]  q7;
   logic [11:0] rem;

   always_comb begin
      q_prod = 25'(s3_sum_ff) * 25'(RECIP7);
      q7     = q_prod[24:16];
      rem    = {1'b0, s3_sum_ff} - ({q7, 3'b000} - {3'd0, q7});
      s4_wday_in = (rem[2:0] == 3'd0) ? 3'd7 : rem[2:0];
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_sec_ff  <= s3_sec_ff;
         s4_min_ff  <= s3_min_ff;
         s4_hr_ff   <= s3_hr_ff;
         s4_day_ff  <= s3_day_ff;
         s4_mon_ff  <= s3_mon_ff;
         s4_year_ff <= s3_year_ff;
         s4_wday_ff <= s4_wday_in;
      end
   end

   assign rsp_valid        = s4_vld_ff;
   assign rsp_seconds      = s4_sec_ff;
   assign rsp_minutes      = s4_min_ff;
   assign rsp_hours        = s4_hr_ff;
   assign rsp_weekday      = s4_wday_ff;
   assign rsp_month_day    = s4_day_ff;
   assign rsp_month        = s4_mon_ff;
   assign rsp_full_year    = s4_year_ff;

endmodule
`default_nettype wire

// ----- rtl/rtn_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtn_csr
// APB-style configuration registers: bcd_mode, twelve_hour_mode, clock_ready.
// ----------------------------------------------------------------------------
module rtn_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [3:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output rtn_pkg::rtn_cfg_type     cfg
);
   import rtn_pkg::*;

   rtn_cfg_type cfg_ff, cfg_in;
   rtn_reg_type reg_sel;
   logic        wr_en;
   logic        rd_bit;

   assign reg_sel = csr_paddr[3:2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_BCD_MODE:    cfg_in.bcd_mode         = csr_pwdata[0];
            REG_TWELVE_HOUR: cfg_in.twelve_hour_mode = csr_pwdata[0];
            REG_CLOCK_READY: cfg_in.clock_ready      = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BCD_MODE:    rd_bit = cfg_ff.bcd_mode;
         REG_TWELVE_HOUR: rd_bit = cfg_ff.twelve_hour_mode;
         REG_CLOCK_READY: rd_bit = cfg_ff.clock_ready;
         default:         rd_bit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = {31'd0, rd_bit};
   assign cfg        = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/rtn_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtn_checker
// Port-level checks on the RTC time normalizer response channel.
// ----------------------------------------------------------------------------
module rtn_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [2:0]   rsp_weekday,
   input wire logic [11:0]  rsp_full_year
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weekday != 3'd0)
      else $error("weekday out of range");

   a_year_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_full_year >= 12'd1970) && (rsp_full_year <= 12'd2255))
      else $error("year outside window");

endmodule

bind rtc_time_normalizer rtn_checker u_rtn_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_weekday   (rsp_weekday),
   .rsp_full_year (rsp_full_year)
);
`default_nettype wire
